FILE: rtl/lr_pkg.sv
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants and controller/datapath interface types for the line
// rasterizer.
// ----------------------------------------------------------------------------
package lr_pkg;

  // Width of every coordinate port
  localparam int unsigned FIELD_W = 6;

  // Default tile size: 2**COORD_BITS pixels on a side
  localparam int unsigned COORD_BITS_DEF = 6;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_in;   // capture a new line request
    logic setup;     // derive major axis, start point and error term
    logic advance;   // step to the next pixel
  } lr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic last;      // current pixel is the line's end point
  } lr_sts_t;

endpackage

FILE: rtl/lr_ctrl.sv
// ----------------------------------------------------------------------------
// lr_ctrl
// Sequencer for the line rasterizer: holds one pending request, runs setup,
// then walks the pixels of the line under output flow control.
// ----------------------------------------------------------------------------
module lr_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output lr_pkg::lr_cmd_t  cmd_o,
  input  lr_pkg::lr_sts_t  sts_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_RUN
  } state_e;

  state_e state_q, state_d;
  logic   pend_q, pend_d;
  logic   in_take, out_take, start;

  // Handshakes
  assign in_take  = in_valid_i && !pend_q;
  assign out_take = (state_q == ST_RUN) && !out_stall_i;

  assign in_stall_o  = pend_q;
  assign out_valid_o = (state_q == ST_RUN);

  // A pending request moves to setup once the previous line is done
  assign start = pend_q && ((state_q == ST_IDLE) || (out_take && sts_i.last));

  assign cmd_o.load_in = in_take;
  assign cmd_o.setup   = (state_q == ST_SETUP);
  assign cmd_o.advance = out_take && !sts_i.last;

  // Next state
  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) state_d = ST_SETUP;
      end
      ST_SETUP: begin
        state_d = ST_RUN;
      end
      ST_RUN: begin
        if (out_take && sts_i.last) state_d = start ? ST_SETUP : ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
    if (start)        pend_d = 1'b0;
    else if (in_take) pend_d = 1'b1;
  end

  // State and pending flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

endmodule

FILE: rtl/lr_dp.sv
// ----------------------------------------------------------------------------
// lr_dp
// Datapath of the line rasterizer: request registers, setup logic and the
// Bresenham stepping registers (major, minor, error term).
// ----------------------------------------------------------------------------
module lr_dp #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic [lr_pkg::FIELD_W-1:0]  start_x_i,
  input  logic [lr_pkg::FIELD_W-1:0]  start_y_i,
  input  logic [lr_pkg::FIELD_W-1:0]  end_x_i,
  input  logic [lr_pkg::FIELD_W-1:0]  end_y_i,
  output logic [lr_pkg::FIELD_W-1:0]  pixel_x_o,
  output logic [lr_pkg::FIELD_W-1:0]  pixel_y_o,
  output logic                        last_pixel_o,
  input  lr_pkg::lr_cmd_t             cmd_i,
  output lr_pkg::lr_sts_t             sts_o
);

  localparam int unsigned CW    = COORD_BITS;
  localparam int unsigned ERR_W = COORD_BITS + 3;

  // Captured request
  logic [CW-1:0] ax_q, ay_q, bx_q, by_q;

  // Stepping state
  logic              xmaj_q;
  logic              neg_q;
  logic [CW-1:0]     maj_q, mnr_q, maj_end_q;
  logic signed [ERR_W-1:0] err_q, inc_lo_q, inc_hi_q;

  // Setup logic
  logic [CW-1:0] dx, dy, dmaj, dmin;
  logic [CW-1:0] maj_a, maj_b, mnr_a, mnr_b;
  logic [CW-1:0] maj_s, mnr_s, maj_e, mnr_e;
  logic          xmaj;
  logic signed [ERR_W-1:0] dmin2, dmaj1, dmaj2, err_init;
  logic signed [ERR_W-1:0] err_next;
  logic          last;

  always_comb begin
    dx    = (bx_q > ax_q) ? (bx_q - ax_q) : (ax_q - bx_q);
    dy    = (by_q > ay_q) ? (by_q - ay_q) : (ay_q - by_q);
    xmaj  = (dx >= dy);
    maj_a = xmaj ? ax_q : ay_q;
    maj_b = xmaj ? bx_q : by_q;
    mnr_a = xmaj ? ay_q : ax_q;
    mnr_b = xmaj ? by_q : bx_q;
    dmaj  = xmaj ? dx : dy;
    dmin  = xmaj ? dy : dx;
    // start from the smaller major coordinate, first endpoint on a tie
    if (maj_a > maj_b) begin
      maj_s = maj_b; mnr_s = mnr_b; maj_e = maj_a; mnr_e = mnr_a;
    end else begin
      maj_s = maj_a; mnr_s = mnr_a; maj_e = maj_b; mnr_e = mnr_b;
    end
    dmin2    = $signed(ERR_W'(dmin) << 1);
    dmaj1    = $signed(ERR_W'(dmaj));
    dmaj2    = $signed(ERR_W'(dmaj) << 1);
    err_init = dmin2 - dmaj1;
  end

  // Error update: one add per pixel
  assign err_next = err_q + ((err_q < 0) ? inc_lo_q : inc_hi_q);
  assign last     = (maj_q >= maj_end_q);

  // Request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      ax_q <= start_x_i[CW-1:0];
      ay_q <= start_y_i[CW-1:0];
      bx_q <= end_x_i[CW-1:0];
      by_q <= end_y_i[CW-1:0];
    end
  end

  // Setup and stepping
  always_ff @(posedge clk_i) begin
    if (cmd_i.setup) begin
      xmaj_q    <= xmaj;
      maj_q     <= maj_s;
      mnr_q     <= mnr_s;
      maj_end_q <= maj_e;
      neg_q     <= !(mnr_e > mnr_s);
      err_q     <= err_init;
      inc_lo_q  <= dmin2;
      inc_hi_q  <= dmin2 - dmaj2;
    end else if (cmd_i.advance) begin
      maj_q <= maj_q + CW'(1);
      if (err_q >= 0) begin
        mnr_q <= neg_q ? (mnr_q - CW'(1)) : (mnr_q + CW'(1));
      end
      err_q <= err_next;
    end
  end

  // Result fields
  assign pixel_x_o    = lr_pkg::FIELD_W'(xmaj_q ? maj_q : mnr_q);
  assign pixel_y_o    = lr_pkg::FIELD_W'(xmaj_q ? mnr_q : maj_q);
  assign last_pixel_o = last;
  assign sts_o.last   = last;

endmodule

FILE: rtl/line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// line_rasterizer_unit
// Integer Bresenham line rasterizer for a square tile: one request in,
// one result per pixel out.
// ----------------------------------------------------------------------------
// Each request gives two endpoints; the unit emits every pixel of the line,
// starting from the endpoint with the smaller major-axis coordinate (x is the
// major axis when |dx| >= |dy|), and flags the final pixel with last_pixel_o.
// From an idle unit the request is first accepted, then the held request is
// handed to setup, then the setup state picks the axis, start point and error
// term, then one pixel per cycle comes from the stepping registers, each held
// while out_stall_i is high.
// A second request is taken and held while the current line is still being
// drawn, so the next line goes to setup straight from the current last pixel.
// Coordinate bits above COORD_BITS are ignored.
module line_rasterizer_unit #(
  parameter int unsigned COORD_BITS = lr_pkg::COORD_BITS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [lr_pkg::FIELD_W-1:0]  start_x_i,
  input  logic [lr_pkg::FIELD_W-1:0]  start_y_i,
  input  logic [lr_pkg::FIELD_W-1:0]  end_x_i,
  input  logic [lr_pkg::FIELD_W-1:0]  end_y_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [lr_pkg::FIELD_W-1:0]  pixel_x_o,
  output logic [lr_pkg::FIELD_W-1:0]  pixel_y_o,
  output logic                        last_pixel_o
);

  lr_pkg::lr_cmd_t cmd;
  lr_pkg::lr_sts_t sts;

  // Sequencer
  lr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Stepping datapath
  lr_dp #(
    .COORD_BITS (COORD_BITS)
  ) u_dp (
    .clk_i        (clk_i),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );

endmodule

FILE: test/tb_line_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// tb_line_rasterizer_unit
// Self-checking testbench for the Bresenham line rasterizer. Each accepted
// line request is rasterized by a behavioral model into a queue of expected
// pixels; every pixel the unit emits is compared against the oldest entry.
// Both handshakes idle and stall at random, with one back-to-back stretch
// and one pause that lets the pixel queue drain.
// ----------------------------------------------------------------------------
module tb_line_rasterizer_unit;

  localparam int unsigned W          = lr_pkg::FIELD_W;
  localparam int unsigned CBITS      = lr_pkg::COORD_BITS_DEF;
  localparam int          COORD_MASK = (1 << CBITS) - 1;
  localparam int          MAX_PIXELS = 64;
  localparam int          IDLE_PCT   = 36;
  localparam int          SETTLE_CYC = 100;
  localparam int          STUCK_LIMIT = 4000;

  typedef struct {
    logic [W-1:0] x;
    logic [W-1:0] y;
    logic         last;
  } pixel_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         in_valid_i = 1'b0;
  logic         in_stall_o;
  logic [W-1:0] start_x_i = '0;
  logic [W-1:0] start_y_i = '0;
  logic [W-1:0] end_x_i = '0;
  logic [W-1:0] end_y_i = '0;
  logic         out_valid_o;
  logic         out_stall_i = 1'b0;
  logic [W-1:0] pixel_x_o;
  logic [W-1:0] pixel_y_o;
  logic         last_pixel_o;

  pixel_t expected_pixels[$];
  int     err_count = 0;
  int     stuck_cycles = 0;
  bit     no_idle = 1'b0;

  line_rasterizer_unit #(
    .COORD_BITS (CBITS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .start_x_i    (start_x_i),
    .start_y_i    (start_y_i),
    .end_x_i      (end_x_i),
    .end_y_i      (end_y_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .pixel_x_o    (pixel_x_o),
    .pixel_y_o    (pixel_y_o),
    .last_pixel_o (last_pixel_o)
  );

  always #5 clk_i = ~clk_i;

  // Bresenham model: appends every pixel of one line to the expected queue
  function automatic void rasterize_line(input logic [W-1:0] sx, input logic [W-1:0] sy,
                                         input logic [W-1:0] ex, input logic [W-1:0] ey);
    int     ax, ay, bx, by, dx, dy, dmaj, dmin;
    int     maj, mnr, maj_end, mnr_end, step, err, n;
    bit     x_major, last;
    pixel_t px;
    ax = int'(sx) & COORD_MASK;
    ay = int'(sy) & COORD_MASK;
    bx = int'(ex) & COORD_MASK;
    by = int'(ey) & COORD_MASK;
    dx = (bx > ax) ? bx - ax : ax - bx;
    dy = (by > ay) ? by - ay : ay - by;
    x_major = (dx >= dy);
    dmaj = x_major ? dx : dy;
    dmin = x_major ? dy : dx;
    // start from the smaller major coordinate; first endpoint wins a tie
    if ((x_major ? ax : ay) > (x_major ? bx : by)) begin
      maj = x_major ? bx : by;  mnr = x_major ? by : bx;
      maj_end = x_major ? ax : ay;  mnr_end = x_major ? ay : ax;
    end else begin
      maj = x_major ? ax : ay;  mnr = x_major ? ay : ax;
      maj_end = x_major ? bx : by;  mnr_end = x_major ? by : bx;
    end
    step = (mnr_end > mnr) ? 1 : -1;
    err = 2 * dmin - dmaj;
    n = 0;
    forever begin
      last = (maj >= maj_end);
      px.x = x_major ? maj[W-1:0] : mnr[W-1:0];
      px.y = x_major ? mnr[W-1:0] : maj[W-1:0];
      px.last = last;
      expected_pixels.push_back(px);
      n++;
      if (last || n >= MAX_PIXELS) break;
      maj++;
      if (err < 0) begin
        err += 2 * dmin;
      end else begin
        mnr += step;
        err += 2 * dmin - 2 * dmaj;
      end
    end
  endfunction

  // Send one line request, with random idle cycles ahead of it
  task automatic send_line(input logic [W-1:0] sx, input logic [W-1:0] sy,
                           input logic [W-1:0] ex, input logic [W-1:0] ey);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i  <= sx;
    start_y_i  <= sy;
    end_x_i    <= ex;
    end_y_i    <= ey;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    rasterize_line(sx, sy, ex, ey);
  endtask

  // Hold off the sender until every pending pixel has come out
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk_i);
  endtask

  // Corners, axis-aligned, diagonals, steep/shallow in both directions
  task automatic test_directed_lines();
    send_line(6'd0, 6'd0, 6'd0, 6'd0);
    send_line(6'd63, 6'd63, 6'd63, 6'd63);
    send_line(6'd0, 6'd0, 6'd63, 6'd0);
    send_line(6'd63, 6'd63, 6'd0, 6'd63);
    send_line(6'd0, 6'd0, 6'd0, 6'd63);
    send_line(6'd63, 6'd63, 6'd63, 6'd0);
    send_line(6'd0, 6'd0, 6'd63, 6'd63);
    send_line(6'd63, 6'd63, 6'd0, 6'd0);
    send_line(6'd0, 6'd63, 6'd63, 6'd0);
    send_line(6'd63, 6'd0, 6'd0, 6'd63);
    // right-to-left lines: minor step is relative to the chosen start
    send_line(6'd50, 6'd5, 6'd10, 6'd30);
    send_line(6'd10, 6'd30, 6'd50, 6'd5);
    send_line(6'd40, 6'd10, 6'd5, 6'd20);
    // steep lines, drawn upward and downward
    send_line(6'd20, 6'd60, 6'd25, 6'd2);
    send_line(6'd25, 6'd2, 6'd20, 6'd60);
    send_line(6'd3, 6'd0, 6'd0, 6'd63);
    // one-step and near-tie slopes
    send_line(6'd31, 6'd31, 6'd32, 6'd32);
    send_line(6'd31, 6'd31, 6'd32, 6'd31);
    send_line(6'd10, 6'd10, 6'd20, 6'd19);
    send_line(6'd10, 6'd10, 6'd19, 6'd20);
    send_line(6'd42, 6'd21, 6'd42, 6'd21);
    send_line(6'd21, 6'd42, 6'd42, 6'd21);
  endtask

  // Random lines: mostly short or random, some axis-aligned, diagonal, points
  task automatic test_random_lines(input int count);
    int           kind;
    logic [W-1:0] sx, sy, ex, ey;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(99);
      sx = W'($urandom);
      sy = W'($urandom);
      ex = W'($urandom);
      ey = W'($urandom);
      if (kind < 25) begin
        ex = sx + W'($urandom_range(8)) - W'(4);
        ey = sy + W'($urandom_range(8)) - W'(4);
      end else if (kind < 35) begin
        ey = sy;
      end else if (kind < 45) begin
        ex = sx;
      end else if (kind < 52) begin
        ey = sy + (ex - sx);
      end else if (kind < 57) begin
        ex = sx;
        ey = sy;
      end
      send_line(sx, sy, ex, ey);
    end
  endtask

  // Back-to-back lines with no idle cycles and no stalls
  task automatic test_back_to_back(input int count);
    no_idle = 1'b1;
    test_random_lines(count);
    no_idle = 1'b0;
  endtask

  // Let the pipe drain fully between bursts
  task automatic test_drain_pause();
    test_random_lines(10);
    wait_drained();
    test_random_lines(10);
  endtask

  // Check each emitted pixel and drive the random output stall
  always @(posedge clk_i) begin
    pixel_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_pixels.size() == 0) begin
        $error("unexpected pixel (%0d,%0d) last=%0d", pixel_x_o, pixel_y_o, last_pixel_o);
        err_count++;
      end else begin
        exp_px = expected_pixels.pop_front();
        if (pixel_x_o !== exp_px.x) begin
          $error("pixel_x: expected %0d, got %0d", exp_px.x, pixel_x_o);
          err_count++;
        end
        if (pixel_y_o !== exp_px.y) begin
          $error("pixel_y: expected %0d, got %0d", exp_px.y, pixel_y_o);
          err_count++;
        end
        if (last_pixel_o !== exp_px.last) begin
          $error("last_pixel: expected %0d, got %0d", exp_px.last, last_pixel_o);
          err_count++;
        end
      end
    end
    out_stall_i <= !no_idle && ($urandom_range(99) < IDLE_PCT);
  end

  // Watchdog: count cycles in which neither side moves an item
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    wait (stuck_cycles >= STUCK_LIMIT);
    $display("tb_line_rasterizer_unit failed");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_lines();
    test_random_lines(130);
    test_back_to_back(60);
    test_drain_pause();
    test_random_lines(120);

    wait_drained();
    repeat (SETTLE_CYC) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb_line_rasterizer_unit passed");
    end else begin
      $display("tb_line_rasterizer_unit failed");
    end
    $finish;
  end

endmodule
